// ----- src/rcve_pkg.sv -----
`timescale 1ns / 1ps
package rcve_pkg;

	localparam int FIELD_W = 11;
	localparam int SIZE_W  = 12;

	localparam logic KIND_PIXEL   = 1'b0;
	localparam logic KIND_READOUT = 1'b1;

	localparam logic RESULT_ROW    = 1'b0;
	localparam logic RESULT_COLUMN = 1'b1;

	localparam logic REG_ACTIVE_COLS = 1'b0;
	localparam logic REG_ACTIVE_ROWS = 1'b1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 12'd2048;

	typedef struct packed {
		logic               result_kind;
		logic [FIELD_W-1:0] line_index;
		logic [FIELD_W-1:0] center;
		logic [FIELD_W-1:0] extent;
	} result_t;

endpackage

// ----- src/rcve_ram.sv -----
`timescale 1ns / 1ps
module rcve_ram #(
	parameter int WIDTH = 23,
	parameter int DEPTH = 2048,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- src/rcve_out_fifo.sv -----
`timescale 1ns / 1ps
module rcve_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rcve_pkg::result_t push_data,
	input  logic              out_stall,
	output logic              out_valid,
	output rcve_pkg::result_t out_data,
	output logic [1:0]        count
);
	import rcve_pkg::*;

	result_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign count     = count_q;
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (count_q != 2'd2))
		else $error("result queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2) && out_stall && !push |=> (count_q == 2'd2))
		else $error("result queue lost an entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("result queue pointers out of step");

endmodule

// ----- src/row_col_valid_extent.sv -----
`timescale 1ns / 1ps
// Row and column extent of valid pixels. Pixels arrive in raster order, one transfer per clock
// while in_stall is low, and positions are counted against active_cols and active_rows. At the
// last pixel of each row a row result (center, extent) follows; a readout transfer returns one
// column's result and clears that column. Each transfer is registered into stage s1, from which
// its result enters a two-entry output queue; in_stall rises when that queue would fill and
// during the clearing pass. The column store is one single-port-write RAM of MAX_COLS words,
// read in the cycle of the transfer and written back in the next, with the previous write
// forwarded to cover back-to-back hits on one column. After reset a clearing pass writes every
// column word while in_stall is held high; configuration writes are taken throughout.
module row_col_valid_extent #(
	parameter int MAX_COLS = 2048,
	parameter int MAX_ROWS = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic        pixel_valid,
	input  logic [10:0] column_select,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [10:0] line_index,
	output logic [10:0] center,
	output logic [10:0] extent,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data
);
	import rcve_pkg::*;

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int LW = (CW > RW) ? CW : RW;
	localparam int WW = 1 + 2 * RW;

	logic [SIZE_W-1:0] active_cols_q;
	logic [SIZE_W-1:0] active_rows_q;
	logic [SIZE_W-1:0] cols_eff;
	logic [SIZE_W-1:0] rows_eff;

	logic [CW-1:0] col_pos_q;
	logic [RW-1:0] row_pos_q;
	logic          row_seen_q;
	logic [CW-1:0] row_low_q;
	logic [CW-1:0] row_high_q;

	logic          clr_active_q;
	logic [CW-1:0] clr_addr_q;

	logic          accept;
	logic          is_pixel;
	logic          row_end;
	logic          frame_end;
	logic          seen_n;
	logic [CW-1:0] low_n;
	logic [CW-1:0] high_n;
	logic          sel_in_range;

	logic          s1_valid_s1;
	logic          s1_kind_s1;
	logic          s1_pv_s1;
	logic [CW-1:0] s1_addr_s1;
	logic          s1_in_range_s1;
	logic [10:0]   s1_col_sel_s1;
	logic [RW-1:0] s1_row_pos_s1;
	logic          s1_row_end_s1;
	logic          s1_row_seen_s1;
	logic [CW-1:0] s1_row_low_s1;
	logic [CW-1:0] s1_row_high_s1;

	logic          ram_wr_en;
	logic [CW-1:0] ram_wr_addr;
	logic [WW-1:0] ram_wr_data;
	logic [CW-1:0] ram_rd_addr;
	logic [WW-1:0] ram_rd_data;

	logic          fw_en_q;
	logic [CW-1:0] fw_addr_q;
	logic [WW-1:0] fw_data_q;

	logic [WW-1:0] word;
	logic          w_seen;
	logic [RW-1:0] w_low;
	logic [RW-1:0] w_high;
	logic [RW-1:0] c_low_n;
	logic [RW-1:0] c_high_n;
	logic          s1_wr_en;
	logic [WW-1:0] s1_wr_data;

	logic              e_seen;
	logic [LW-1:0]     e_low;
	logic [LW-1:0]     e_high;
	logic [LW:0]       e_sum;
	logic [SIZE_W-1:0] e_size;
	logic              s1_res;
	result_t           res;

	logic       pop;
	logic [1:0] fifo_count;
	logic [2:0] fill_next;
	result_t    out_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_cols_q <= SIZE_RESET;
			active_rows_q <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ACTIVE_COLS: active_cols_q <= cfg_data;
				REG_ACTIVE_ROWS: active_rows_q <= cfg_data;
			endcase
		end
	end

	assign cols_eff = (active_cols_q == '0) ? 12'd1 :
		(32'(active_cols_q) > MAX_COLS) ? 12'(MAX_COLS) : active_cols_q;
	assign rows_eff = (active_rows_q == '0) ? 12'd1 :
		(32'(active_rows_q) > MAX_ROWS) ? 12'(MAX_ROWS) : active_rows_q;

	assign pop       = out_valid && !out_stall;
	assign fill_next = {1'b0, fifo_count} - {2'b0, pop} + {2'b0, s1_res};
	assign in_stall  = clr_active_q || (fill_next > 3'd1);
	assign accept    = in_valid && !in_stall;
	assign is_pixel  = (kind == KIND_PIXEL);

	assign row_end   = (32'(col_pos_q) + 32'd1) >= 32'(cols_eff);
	assign frame_end = (32'(row_pos_q) + 32'd1) >= 32'(rows_eff);
	assign seen_n    = row_seen_q || pixel_valid;
	assign low_n     = (pixel_valid && (!row_seen_q || col_pos_q < row_low_q)) ?
		col_pos_q : row_low_q;
	assign high_n    = (pixel_valid && (!row_seen_q || col_pos_q > row_high_q)) ?
		col_pos_q : row_high_q;
	assign sel_in_range = 32'(column_select) < MAX_COLS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q  <= '0;
			row_pos_q  <= '0;
			row_seen_q <= 1'b0;
		end else if (accept && is_pixel) begin
			if (row_end) begin
				col_pos_q  <= '0;
				row_seen_q <= 1'b0;
				row_pos_q  <= frame_end ? '0 : row_pos_q + 1'b1;
			end else begin
				col_pos_q  <= col_pos_q + 1'b1;
				row_seen_q <= seen_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_pixel) begin
			row_low_q  <= low_n;
			row_high_q <= high_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == CW'(MAX_COLS - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else begin
			s1_valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_kind_s1     <= kind;
			s1_pv_s1       <= pixel_valid;
			s1_addr_s1     <= ram_rd_addr;
			s1_in_range_s1 <= sel_in_range;
			s1_col_sel_s1  <= column_select;
			s1_row_pos_s1  <= row_pos_q;
			s1_row_end_s1  <= row_end;
			s1_row_seen_s1 <= seen_n;
			s1_row_low_s1  <= low_n;
			s1_row_high_s1 <= high_n;
		end
	end

	assign ram_rd_addr = is_pixel ? col_pos_q : CW'(column_select);

	rcve_ram #(
		.WIDTH(WW),
		.DEPTH(MAX_COLS)
	) u_col_store (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (accept),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// forward the write of the previous cycle, which the RAM read did not yet see
	assign word   = (fw_en_q && fw_addr_q == s1_addr_s1) ? fw_data_q : ram_rd_data;
	assign w_seen = word[WW-1];
	assign w_low  = word[2*RW-1:RW];
	assign w_high = word[RW-1:0];

	assign c_low_n  = (!w_seen || s1_row_pos_s1 < w_low) ? s1_row_pos_s1 : w_low;
	assign c_high_n = (!w_seen || s1_row_pos_s1 > w_high) ? s1_row_pos_s1 : w_high;

	always_comb begin
		s1_wr_en   = 1'b0;
		s1_wr_data = {1'b0, w_low, w_high};
		if (s1_valid_s1) begin
			if (s1_kind_s1 == KIND_PIXEL) begin
				s1_wr_en   = s1_pv_s1;
				s1_wr_data = {1'b1, c_low_n, c_high_n};
			end else begin
				s1_wr_en = s1_in_range_s1;
			end
		end
	end

	assign ram_wr_en   = clr_active_q || s1_wr_en;
	assign ram_wr_addr = clr_active_q ? clr_addr_q : s1_addr_s1;
	assign ram_wr_data = clr_active_q ? '0 : s1_wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_en_q <= 1'b0;
		end else begin
			fw_en_q <= ram_wr_en;
		end
	end

	always_ff @(posedge clk) begin
		fw_addr_q <= ram_wr_addr;
		fw_data_q <= ram_wr_data;
	end

	always_comb begin
		if (s1_kind_s1 == KIND_READOUT) begin
			e_seen = s1_in_range_s1 && w_seen;
			e_low  = LW'(w_low);
			e_high = LW'(w_high);
			e_size = rows_eff;
			res.result_kind = RESULT_COLUMN;
			res.line_index  = s1_col_sel_s1;
		end else begin
			e_seen = s1_row_seen_s1;
			e_low  = LW'(s1_row_low_s1);
			e_high = LW'(s1_row_high_s1);
			e_size = cols_eff;
			res.result_kind = RESULT_ROW;
			res.line_index  = 11'(s1_row_pos_s1);
		end
		e_sum      = {1'b0, e_low} + {1'b0, e_high};
		res.center = e_seen ? 11'(e_sum[LW:1]) : e_size[SIZE_W-1:1];
		res.extent = e_seen ? 11'(e_high - e_low) : '0;
	end

	assign s1_res = s1_valid_s1 && ((s1_kind_s1 == KIND_READOUT) || s1_row_end_s1);

	rcve_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s1_res),
		.push_data(res),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_data (out_data),
		.count    (fifo_count)
	);

	assign result_kind = out_data.result_kind;
	assign line_index  = out_data.line_index;
	assign center      = out_data.center;
	assign extent      = out_data.extent;

	assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !accept && !s1_valid_s1)
		else $error("transfer taken during clearing pass");

	assert property (@(posedge clk) disable iff (!arst_n)
		!clr_active_q |=> !clr_active_q)
		else $error("clearing pass restarted");

	assert property (@(posedge clk) disable iff (!arst_n)
		s1_res |-> (fifo_count != 2'd2) || pop)
		else $error("result produced with no queue space");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

// ----- sim/row_col_valid_extent_checker.sv -----
`timescale 1ns / 1ps
module row_col_valid_extent_checker #(
	parameter int MAX_COLS = 2048,
	parameter int MAX_ROWS = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        kind,
	input  logic        pixel_valid,
	input  logic [10:0] column_select,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        result_kind,
	input  logic [10:0] line_index,
	input  logic [10:0] center,
	input  logic [10:0] extent,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data,
	output int          mismatch_count,
	output int          pending_count,
	output int          checked_count
);
	import rcve_pkg::*;

	logic [SIZE_W-1:0] width_reg;
	logic [SIZE_W-1:0] height_reg;
	int                col_at;
	int                row_at;
	bit                run_hit;
	int                run_lo;
	int                run_hi;
	bit                col_hit [MAX_COLS];
	int                col_first [MAX_COLS];
	int                col_last [MAX_COLS];
	result_t           expected_extents [$];
	int                fails;
	int                checked;

	function automatic int effective_size(input logic [SIZE_W-1:0] r, input int limit);
		if (r == 0)
			return 1;
		if (int'(r) > limit)
			return limit;
		return int'(r);
	endfunction

	function automatic result_t line_summary(input logic rk, input int idx, input bit seen,
			input int lo, input int hi, input int size);
		result_t r;
		r.result_kind = rk;
		r.line_index = FIELD_W'(idx);
		r.center = seen ? FIELD_W'((lo + hi) / 2) : FIELD_W'(size / 2);
		r.extent = seen ? FIELD_W'(hi - lo) : '0;
		return r;
	endfunction

	task automatic track_transfer(input logic k, input logic pv, input logic [10:0] sel);
		int cols;
		int rows;
		cols = effective_size(width_reg, MAX_COLS);
		rows = effective_size(height_reg, MAX_ROWS);
		if (k == KIND_READOUT) begin
			if (int'(sel) < MAX_COLS) begin
				expected_extents.push_back(line_summary(RESULT_COLUMN, int'(sel), col_hit[sel],
					col_first[sel], col_last[sel], rows));
				col_hit[sel] = 1'b0;
			end else begin
				expected_extents.push_back(line_summary(RESULT_COLUMN, int'(sel), 1'b0, 0, 0,
					rows));
			end
			return;
		end
		if (col_at >= MAX_COLS)
			col_at = 0;
		if (row_at >= MAX_ROWS)
			row_at = 0;
		if (pv) begin
			if (!run_hit) begin
				run_lo = col_at;
				run_hi = col_at;
				run_hit = 1'b1;
			end else begin
				if (col_at < run_lo)
					run_lo = col_at;
				if (col_at > run_hi)
					run_hi = col_at;
			end
			if (!col_hit[col_at]) begin
				col_first[col_at] = row_at;
				col_last[col_at] = row_at;
				col_hit[col_at] = 1'b1;
			end else begin
				if (row_at < col_first[col_at])
					col_first[col_at] = row_at;
				if (row_at > col_last[col_at])
					col_last[col_at] = row_at;
			end
		end
		if (col_at + 1 >= cols) begin
			expected_extents.push_back(line_summary(RESULT_ROW, row_at, run_hit, run_lo, run_hi,
				cols));
			run_hit = 1'b0;
			col_at = 0;
			row_at = (row_at + 1 >= rows) ? 0 : row_at + 1;
		end else begin
			col_at++;
		end
	endtask

	task automatic compare_result();
		result_t got;
		result_t want;
		got.result_kind = result_kind;
		got.line_index = line_index;
		got.center = center;
		got.extent = extent;
		checked++;
		if (expected_extents.size() == 0) begin
			fails++;
			if (fails <= 10)
				$display("%0t: unexpected result kind %0d line %0d center %0d extent %0d",
					$realtime, got.result_kind, got.line_index, got.center, got.extent);
		end else begin
			want = expected_extents.pop_front();
			if (got.result_kind !== want.result_kind || got.line_index !== want.line_index ||
					got.center !== want.center || got.extent !== want.extent) begin
				fails++;
				if (fails <= 10) begin
					$display("%0t: mismatch, expected kind %0d line %0d center %0d extent %0d",
						$realtime, want.result_kind, want.line_index, want.center,
						want.extent);
					$display("    actual kind %0d line %0d center %0d extent %0d",
						got.result_kind, got.line_index, got.center, got.extent);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = SIZE_RESET;
			height_reg = SIZE_RESET;
			col_at = 0;
			row_at = 0;
			run_hit = 1'b0;
			run_lo = 0;
			run_hi = 0;
			for (int c = 0; c < MAX_COLS; c++)
				col_hit[c] = 1'b0;
			expected_extents.delete();
			fails = 0;
			checked = 0;
			mismatch_count <= 0;
			pending_count <= 0;
			checked_count <= 0;
		end else begin
			if (out_valid && !out_stall)
				compare_result();
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ACTIVE_COLS)
					width_reg = cfg_data;
				else
					height_reg = cfg_data;
			end
			if (in_valid && !in_stall)
				track_transfer(kind, pixel_valid, column_select);
			mismatch_count <= fails;
			pending_count <= expected_extents.size();
			checked_count <= checked;
		end
	end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import rcve_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = KIND_PIXEL;
	logic        pixel_valid = 1'b0;
	logic [10:0] column_select = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        result_kind;
	logic [10:0] line_index;
	logic [10:0] center;
	logic [10:0] extent;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_ACTIVE_COLS;
	logic [11:0] cfg_data = '0;

	int mismatch_count;
	int pending_count;
	int checked_count;

	int   send_gap_pct = 0;
	int   stall_pct = 0;
	logic hold_trigger = 1'b0;
	logic hold_ack;
	int   hold_left;

	int pixels_sent = 0;
	int readouts_sent = 0;
	int settings_used = 0;
	int cols_set;
	int rows_set;
	int cols_eff;
	int rows_eff;
	int budget;
	int phase_end;
	int density;
	logic [15:0] bits;

	row_col_valid_extent dut (.*);

	row_col_valid_extent_checker chk (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_ack <= 1'b0;
			hold_left <= 0;
		end else if (hold_trigger != hold_ack) begin
			hold_ack <= hold_trigger;
			hold_left <= 400;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic int clamp_size(input int r);
		if (r == 0)
			return 1;
		return (r > 2048) ? 2048 : r;
	endfunction

	task automatic send_item(input logic k, input logic pv, input logic [10:0] sel);
		int gap;
		if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		pixel_valid <= pv;
		column_select <= sel;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (k == KIND_PIXEL)
			pixels_sent++;
		else
			readouts_sent++;
	endtask

	task automatic send_row(input int n, input logic [15:0] row_bits);
		for (int i = 0; i < n; i++)
			send_item(KIND_PIXEL, row_bits[i], 11'($urandom_range(2047)));
	endtask

	task automatic read_column(input int c);
		send_item(KIND_READOUT, 1'($urandom), 11'(c));
	endtask

	task automatic write_sizes(input logic [11:0] cols, input logic [11:0] rows);
		cfg_valid <= 1'b1;
		cfg_index <= REG_ACTIVE_COLS;
		cfg_data <= cols;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= REG_ACTIVE_ROWS;
		cfg_data <= rows;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic settle(input int tail);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		write_sizes(12'd4, 12'd3);
		send_row(4, 16'b0110);
		send_row(4, 16'b0000);
		send_row(4, 16'b1001);
		read_column(0);
		read_column(1);
		read_column(2047);
		read_column(1);
		// leave columns 2 and 3 set so the next frame merges into them
		send_row(4, 16'b1111);
		read_column(3);
		read_column(2);

		for (int p = 0; p < 18; p++) begin
			settle(8);
			budget = 50;
			case (p)
				0: begin
					cols_set = 2048;
					rows_set = 2048;
				end
				1: begin
					cols_set = 1;
					rows_set = 1;
					budget = 60;
				end
				2: begin
					cols_set = 0;
					rows_set = 0;
					budget = 60;
				end
				3: begin
					cols_set = 4095;
					rows_set = 3;
					budget = 60;
				end
				5: begin
					cols_set = 0;
					rows_set = 4095;
					budget = 200;
				end
				default: begin
					cols_set = $urandom_range(1, 16);
					rows_set = (p % 5 == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
				end
			endcase
			cols_eff = clamp_size(cols_set);
			rows_eff = clamp_size(rows_set);
			write_sizes(12'(cols_set), 12'(rows_set));
			case (p % 4)
				0: begin
					send_gap_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					send_gap_pct = 58;
					stall_pct <= 0;
				end
				2: begin
					send_gap_pct = 0;
					stall_pct <= 58;
				end
				default: begin
					send_gap_pct = 36;
					stall_pct <= 36;
				end
			endcase
			// hold the receiver off while pixels keep coming, to back up the block
			if (p == 4)
				hold_trigger <= ~hold_trigger;

			if (p == 0) begin
				for (int i = 0; i < 200; i++)
					send_item(KIND_PIXEL, (i == 0) || (i == 199) ||
						($urandom_range(99) < 4), 11'($urandom_range(2047)));
				read_column(0);
				read_column(2047);
				repeat (4) read_column($urandom_range(2047));
			end else begin
				phase_end = pixels_sent + readouts_sent + budget;
				while (pixels_sent + readouts_sent < phase_end) begin
					if (cols_eff * rows_eff <= 512 && $urandom_range(99) < 75) begin
						density = $urandom_range(4);
						for (int r = 0; r < rows_eff; r++) begin
							case (density)
								0: bits = '0;
								1: bits = '1;
								2: bits = 16'($urandom);
								3: bits = 16'($urandom & $urandom);
								default: bits = 16'(1) << $urandom_range(cols_eff - 1);
							endcase
							send_row(cols_eff, bits);
						end
						if ($urandom_range(99) < 85) begin
							if ($urandom_range(1))
								for (int c = 0; c < cols_eff; c++)
									read_column(c);
							else
								for (int c = cols_eff - 1; c >= 0; c--)
									read_column(c);
						end
					end else begin
						repeat ($urandom_range(1, 12)) begin
							if ($urandom_range(99) < 80)
								send_item(KIND_PIXEL, 1'($urandom),
									11'($urandom_range(2047)));
							else if ($urandom_range(1))
								read_column($urandom_range(cols_eff - 1));
							else
								read_column($urandom_range(2047));
						end
					end
				end
			end
		end

		send_gap_pct = 0;
		stall_pct <= 0;
		settle(16);
		$display("Sent %0d pixel and %0d readout transfers across %0d frame size settings",
			pixels_sent, readouts_sent, settings_used);
		$display("Checked %0d row and column extent results", checked_count);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- row_col_valid_extent.f -----
src/rcve_pkg.sv
src/rcve_ram.sv
src/rcve_out_fifo.sv
src/row_col_valid_extent.sv
sim/row_col_valid_extent_checker.sv
sim/testbench.sv
